>>> sv/tmr_pkg.sv
// tmr_pkg: shared types and constants of the text message reassembler
// no dependencies; compiled first

package tmr_pkg;

	localparam int BLOCK_BYTES = 13;
	localparam int BLOCK_COUNT = 4;
	localparam int SLOT_W      = 2;
	localparam int OFF_W       = 4;
	localparam int TEXT_W      = BLOCK_BYTES * 8;

	// valid total-block masks (upper control nibble)
	localparam logic [3:0] TOTAL_ONE   = 4'h1;
	localparam logic [3:0] TOTAL_TWO   = 4'h3;
	localparam logic [3:0] TOTAL_THREE = 4'h7;
	localparam logic [3:0] TOTAL_FOUR  = 4'hf;

	// one-hot block indexes (lower control nibble)
	localparam logic [3:0] INDEX_0 = 4'h1;
	localparam logic [3:0] INDEX_1 = 4'h2;
	localparam logic [3:0] INDEX_2 = 4'h4;
	localparam logic [3:0] INDEX_3 = 4'h8;

	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] GRAPH_LO   = 8'h21;
	localparam logic [7:0] GRAPH_HI   = 8'h7e;

	localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(BLOCK_BYTES - 1);

	typedef enum logic [1:0] {
		KIND_IGNORE,
		KIND_BAD,
		KIND_STORE
	} kind_t;

	// one classified block request, front to back
	typedef struct packed {
		kind_t              kind;
		logic [SLOT_W-1:0]  slot;
		logic [7:0]         ctl;
		logic [TEXT_W-1:0]  text;
		logic               nonempty;
		logic [OFF_W-1:0]   first_off;
		logic [OFF_W-1:0]   last_off;
	} cmd_t;

	// one result item
	typedef struct packed {
		logic       acc;
		logic       comp;
		logic       has;
		logic [7:0] ch;
		logic       last;
	} res_t;

endpackage

>>> sv/tmr_blk_if.sv
// tmr_blk_if: block request channel (valid/ready plus block payload)
// no dependencies

interface tmr_blk_if;
	logic        valid;
	logic        ready;
	logic [7:0]  control_byte;
	logic [63:0] payload_low;
	logic [39:0] payload_high;

	modport source (output valid, control_byte, payload_low, payload_high, input ready);
	modport sink   (input valid, control_byte, payload_low, payload_high, output ready);
endinterface

>>> sv/tmr_res_if.sv
// tmr_res_if: result channel (valid/ready plus result fields)
// no dependencies

interface tmr_res_if;
	logic       valid;
	logic       ready;
	logic       block_accepted;
	logic       message_complete;
	logic       has_char;
	logic [7:0] char_value;
	logic       last_result;

	modport source (output valid, block_accepted, message_complete, has_char, char_value,
		last_result, input ready);
	modport sink   (input valid, block_accepted, message_complete, has_char, char_value,
		last_result, output ready);
endinterface

>>> sv/tmr_ram.sv
// tmr_ram: generic single-write, single-read ram with registered read data
// no dependencies

module tmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/tmr_front.sv
// tmr_front: decodes the control byte, cleans the payload, finds trim offsets
// depends on tmr_pkg and tmr_blk_if

module tmr_front import tmr_pkg::*; (
	tmr_blk_if.sink blk,
	output cmd_t    cmd,
	output logic    cmd_valid,
	input  logic    cmd_ready
);

	logic [3:0]        total;
	logic [3:0]        index;
	logic              total_ok;
	logic              index_ok;
	logic [SLOT_W-1:0] slot;
	logic [TEXT_W-1:0] raw;
	logic [TEXT_W-1:0] text;
	logic [BLOCK_BYTES-1:0] graph;
	logic [OFF_W-1:0]  first_off;
	logic [OFF_W-1:0]  last_off;
	logic [7:0]        b;

	assign total = blk.control_byte[7:4];
	assign index = blk.control_byte[3:0];
	assign raw   = {blk.payload_high, blk.payload_low};

	assign total_ok = (total == TOTAL_ONE) || (total == TOTAL_TWO) ||
		(total == TOTAL_THREE) || (total == TOTAL_FOUR);

	always_comb begin
		index_ok = 1'b1;
		slot     = '0;
		case (index)
			INDEX_0: slot = 2'd0;
			INDEX_1: slot = 2'd1;
			INDEX_2: slot = 2'd2;
			INDEX_3: slot = 2'd3;
			default: index_ok = 1'b0;
		endcase
	end

	// non-graphic bytes become spaces
	always_comb begin
		text  = '0;
		graph = '0;
		b     = '0;
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			b = raw[i*8 +: 8];
			graph[i] = (b >= GRAPH_LO) && (b <= GRAPH_HI);
			text[i*8 +: 8] = graph[i] ? b : SPACE_CHAR;
		end
	end

	// first and last graphic byte within the block
	always_comb begin
		first_off = '0;
		last_off  = '0;
		for (int i = BLOCK_BYTES - 1; i >= 0; i--) begin
			if (graph[i]) first_off = OFF_W'(i);
		end
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			if (graph[i]) last_off = OFF_W'(i);
		end
	end

	always_comb begin
		cmd.kind      = KIND_STORE;
		if (blk.control_byte == 8'h00) cmd.kind = KIND_IGNORE;
		else if (!total_ok || !index_ok) cmd.kind = KIND_BAD;
		cmd.slot      = slot;
		cmd.ctl       = blk.control_byte;
		cmd.text      = text;
		cmd.nonempty  = |graph;
		cmd.first_off = first_off;
		cmd.last_off  = last_off;
	end

	assign cmd_valid = blk.valid;
	assign blk.ready = cmd_ready;

endmodule

>>> sv/tmr_queue.sv
// tmr_queue: short fifo of classified block requests between front and back
// depends on tmr_pkg

module tmr_queue import tmr_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t push_data,
	input  logic push_valid,
	output logic push_ready,
	output cmd_t pop_data,
	output logic pop_valid,
	input  logic pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> sv/tmr_back.sv
// tmr_back: applies block requests to the slot store and emits result items
// depends on tmr_pkg, tmr_res_if and tmr_ram

module tmr_back import tmr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             q_cmd,
	input  logic             q_valid,
	output logic             q_ready,
	tmr_res_if.source        res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_LOAD,
		S_EMIT
	} state_t;

	state_t             state_q;
	logic [7:0]         seen_q;
	logic [BLOCK_COUNT-1:0] written_q;
	logic [BLOCK_COUNT-1:0] nonempty_q;
	logic [OFF_W-1:0]   first_off_q [BLOCK_COUNT];
	logic [OFF_W-1:0]   last_off_q  [BLOCK_COUNT];
	logic [SLOT_W-1:0]  cur_slot_q;
	logic [OFF_W-1:0]   cur_off_q;
	logic [SLOT_W-1:0]  end_slot_q;
	logic [OFF_W-1:0]   end_off_q;
	logic               out_valid_q;
	res_t               out_q;

	logic               out_free;
	logic               pop;
	logic               complete;
	logic               run;
	logic               res_load;
	logic [BLOCK_COUNT-1:0] use_slot;
	logic [SLOT_W-1:0]  start_slot;
	logic [OFF_W-1:0]   start_off;
	logic [SLOT_W-1:0]  stop_slot;
	logic [OFF_W-1:0]   stop_off;
	logic [TEXT_W-1:0]  ram_rdata;
	logic [7:0]         cur_byte;
	logic               last_char;

	function automatic res_t make_res(logic acc, logic comp, logic has, logic [7:0] ch,
		logic last);
		res_t r;
		r.acc  = acc;
		r.comp = comp;
		r.has  = has;
		r.ch   = ch;
		r.last = last;
		return r;
	endfunction

	assign out_free = !out_valid_q || res.ready;
	assign q_ready  = (state_q == S_IDLE) && ((q_cmd.kind == KIND_STORE) || out_free);
	assign pop      = q_valid && q_ready;
	assign complete = (seen_q[3:0] == seen_q[7:4]);

	tmr_ram #(
		.WIDTH (TEXT_W),
		.DEPTH (BLOCK_COUNT)
	) u_text_ram (
		.clk   (clk),
		.we    (pop && (q_cmd.kind == KIND_STORE)),
		.waddr (q_cmd.slot),
		.wdata (q_cmd.text),
		.raddr (cur_slot_q),
		.rdata (ram_rdata)
	);

	// text runs over the written prefix of slots; trim to first/last graphic byte
	always_comb begin
		run        = 1'b1;
		use_slot   = '0;
		start_slot = '0;
		start_off  = '0;
		stop_slot  = '0;
		stop_off   = '0;
		for (int s = 0; s < BLOCK_COUNT; s++) begin
			run = run && written_q[s];
			use_slot[s] = run && nonempty_q[s];
		end
		for (int s = BLOCK_COUNT - 1; s >= 0; s--) begin
			if (use_slot[s]) begin
				start_slot = SLOT_W'(s);
				start_off  = first_off_q[s];
			end
		end
		for (int s = 0; s < BLOCK_COUNT; s++) begin
			if (use_slot[s]) begin
				stop_slot = SLOT_W'(s);
				stop_off  = last_off_q[s];
			end
		end
	end

	// a new result goes into the output register this cycle
	always_comb begin
		res_load = 1'b0;
		case (state_q)
			S_IDLE:  res_load = pop && (q_cmd.kind != KIND_STORE);
			S_CHECK: res_load = out_free && !(complete && (use_slot != '0));
			S_EMIT:  res_load = out_free;
			default: res_load = 1'b0;
		endcase
	end

	assign cur_byte  = ram_rdata[{cur_off_q, 3'b000} +: 8];
	assign last_char = (cur_slot_q == end_slot_q) && (cur_off_q == end_off_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seen_q      <= '0;
			written_q   <= '0;
			nonempty_q  <= '0;
			for (int s = 0; s < BLOCK_COUNT; s++) begin
				first_off_q[s] <= '0;
				last_off_q[s]  <= '0;
			end
			cur_slot_q  <= '0;
			cur_off_q   <= '0;
			end_slot_q  <= '0;
			end_off_q   <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && res.ready && !res_load) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						case (q_cmd.kind)
							KIND_STORE: begin
								seen_q                  <= seen_q | q_cmd.ctl;
								written_q[q_cmd.slot]   <= 1'b1;
								nonempty_q[q_cmd.slot]  <= q_cmd.nonempty;
								first_off_q[q_cmd.slot] <= q_cmd.first_off;
								last_off_q[q_cmd.slot]  <= q_cmd.last_off;
								state_q                 <= S_CHECK;
							end
							KIND_BAD: begin
								seen_q      <= '0;
								written_q   <= '0;
								out_valid_q <= 1'b1;
								out_q       <= make_res(1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
							end
							default: begin
								out_valid_q <= 1'b1;
								out_q       <= make_res(1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
							end
						endcase
					end
				end
				S_CHECK: begin
					if (!complete) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							out_q       <= make_res(1'b1, 1'b0, 1'b0, 8'h00, 1'b1);
							state_q     <= S_IDLE;
						end
					end else if (use_slot == '0) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							out_q       <= make_res(1'b1, 1'b1, 1'b0, 8'h00, 1'b1);
							state_q     <= S_IDLE;
						end
					end else begin
						cur_slot_q <= start_slot;
						cur_off_q  <= start_off;
						end_slot_q <= stop_slot;
						end_off_q  <= stop_off;
						state_q    <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q       <= make_res(1'b1, 1'b1, 1'b1, cur_byte, last_char);
						if (last_char) begin
							state_q <= S_IDLE;
						end else if (cur_off_q == LAST_OFF) begin
							cur_slot_q <= cur_slot_q + 1'b1;
							cur_off_q  <= '0;
							state_q    <= S_LOAD;
						end else begin
							cur_off_q <= cur_off_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.valid            = out_valid_q;
	assign res.block_accepted   = out_q.acc;
	assign res.message_complete = out_q.comp;
	assign res.has_char         = out_q.has;
	assign res.char_value       = out_q.ch;
	assign res.last_result      = out_q.last;

endmodule

>>> sv/text_message_reassembler.sv
// text_message_reassembler: top level of the text message block reassembler
// depends on tmr_pkg, tmr_blk_if, tmr_res_if, tmr_front, tmr_queue, tmr_back

// Takes one 13-byte text block per request on blk and answers on res. The
// front decodes the control byte (upper nibble: mask of blocks in the
// message, lower nibble: one-hot block index), turns non-graphic payload
// bytes into spaces and finds the first and last graphic byte of the block;
// the request then waits in a short queue (QUEUE_DEPTH entries) so blk keeps
// flowing while the back is busy emitting. The back owns the seen mask and
// the four block slots (one 104-bit ram row each, plus per-slot written and
// trim bits in flops, so reset needs no clearing pass). A zero control byte
// gives one empty result; a malformed one clears the message and gives one
// empty result; a stored block that does not finish the message gives one
// result with block_accepted set. When the mask nibbles match, the text
// (written slots from slot 0 on, trimmed of outer spaces) is sent one
// character per result with last_result on the final one, or as one result
// with no character if that text is empty. The back takes no new request
// until it is back in idle; it sends one character per cycle while res is
// ready, from a single registered ram read port, and passes through a
// reload state before each further slot.

module text_message_reassembler import tmr_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	tmr_blk_if.sink   blk,
	tmr_res_if.source res
);

	// front to queue
	cmd_t front_cmd;
	logic front_valid;
	logic front_ready;

	// queue to back
	cmd_t back_cmd;
	logic back_valid;
	logic back_ready;

	// decode and clean the incoming block
	tmr_front u_front (
		.blk       (blk),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	// decouples block intake from character emission
	tmr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (front_cmd),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_data   (back_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	// slot store, seen mask and result sequencer
	tmr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_cmd   (back_cmd),
		.q_valid (back_valid),
		.q_ready (back_ready),
		.res     (res)
	);

endmodule

>>> sv/tmr_checker.sv
// tmr_checker: port-level assertions on the result channel of the reassembler
// bound to text_message_reassembler; no package dependencies

module tmr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       block_accepted,
	input logic       message_complete,
	input logic       has_char,
	input logic [7:0] char_value,
	input logic       last_result
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid &&
		$stable({block_accepted, message_complete, has_char, char_value, last_result}))
		else $error("result changed while stalled");

	// characters only come out of a completed message
	a_char_needs_complete: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && has_char |-> message_complete && block_accepted)
		else $error("character without completed message");

	// completion only on a stored block
	a_complete_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && message_complete |-> block_accepted)
		else $error("completion without accepted block");

	// a result without a character is always the only result of its request
	a_no_char_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !has_char |-> (char_value == 8'h00) && last_result)
		else $error("characterless result not single or not zero");

endmodule

bind text_message_reassembler tmr_checker u_tmr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.block_accepted   (res.block_accepted),
	.message_complete (res.message_complete),
	.has_char         (res.has_char),
	.char_value       (res.char_value),
	.last_result      (res.last_result)
);
